// ===== rtl/core/base32hex_stream_encoder_macros.svh =====
// Assertion macros shared by the base32hex encoder modules.
`ifndef BASE32HEX_STREAM_ENCODER_MACROS_SVH
`define BASE32HEX_STREAM_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF
`define B32H_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("base32hex encoder assertion failed");
`define B32H_ASSERT_MSG(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
`else
`define B32H_ASSERT(lbl, prop)
`define B32H_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/b32h_pkg.sv =====
// Shared types, constants and the alphabet function of the base32hex encoder.
`timescale 1ns / 1ps

package b32h_pkg;

   localparam int unsigned GROUP_CHARS = 8;
   localparam logic [7:0] PAD_CHAR = 8'h3d;
   localparam logic [7:0] DIGIT_BASE = 8'h30;
   localparam logic [7:0] LETTER_BASE = 8'h57;

   typedef struct packed {
      logic [GROUP_CHARS-1:0][7:0] chars;
      logic [2:0]                  rem;
      logic                        last;
   } b32h_bundle_type;

   function automatic logic [7:0] b32h_char(input logic [4:0] sym);
      logic [7:0] wide;
      wide = {3'b000, sym};
      if (sym < 5'd10) begin
         b32h_char = DIGIT_BASE + wide;
      end else begin
         b32h_char = LETTER_BASE + wide;
      end
   endfunction

endpackage

// ===== rtl/core/base32hex_stream_encoder.sv =====
// Top level of the base32hex stream encoder.
// Usage: each item on the req_ channel is one message byte (req_data_byte) with
// req_last_byte set on the final byte of a message. Each item on the rsp_
// channel is one ASCII character of the lower-case extended-hex base32 text,
// with rsp_end_of_text set on the final character, after any '=' padding.
// A byte is accepted when req_valid is high and req_stall is low; a character
// is taken when rsp_valid is high and rsp_stall is low.
// Each accepted byte is held in the bundle register, and its characters move
// from there to the output register. The output register sends one character
// per cycle while rsp_stall is low. A byte yields 1 or 2 characters in
// steady state and a last byte up to 8 characters, including padding. The bundle
// register takes the next byte in the cycle its last character moves to the output register.
// Reset clears the group position, the leftover bits and both valid flags,
// so the next byte starts a new message. While the receiver stalls, the
// current character holds on rsp_ and req_stall rises once the bundle
// register is still full.
`timescale 1ns / 1ps

module base32hex_stream_encoder import b32h_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_end_of_text
);

   b32h_bundle_type bundle;
   logic            slot_free;
   logic            accept;

   assign req_stall = !slot_free;
   assign accept    = req_valid && slot_free;

   b32h_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .bundle    (bundle)
   );

   b32h_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .bundle          (bundle),
      .slot_free       (slot_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_end_of_text (rsp_end_of_text)
   );

endmodule

// ===== rtl/core/b32h_encoder.sv =====
// Group-position state and per-byte character bundle generation.
`timescale 1ns / 1ps
`include "base32hex_stream_encoder_macros.svh"

module b32h_encoder import b32h_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      data_byte,
   input  logic            last_byte,
   output b32h_bundle_type bundle
);

   logic [3:0] carry_bits_ff;
   logic [3:0] carry_bits_in;
   logic [2:0] group_position_ff;
   logic [2:0] group_position_in;
   logic [4:0] sym0;
   logic [4:0] sym1;
   logic [4:0] flush_sym;
   logic       two_chars;
   logic       has_flush;
   logic [3:0] carry_next;
   logic [2:0] pos_next;
   logic [2:0] rem_last;
   logic [2:0] rem_mid;

   always_comb begin
      sym1      = data_byte[4:0];
      two_chars = 1'b1;
      has_flush = 1'b1;
      case (group_position_ff)
         3'd1: begin
            sym0       = {carry_bits_ff[2:0], data_byte[7:6]};
            sym1       = data_byte[5:1];
            carry_next = {3'b000, data_byte[0]};
            flush_sym  = {data_byte[0], 4'b0000};
            pos_next   = 3'd2;
            rem_last   = 3'd6;
            rem_mid    = 3'd1;
         end
         3'd2: begin
            sym0       = {carry_bits_ff[0], data_byte[7:4]};
            two_chars  = 1'b0;
            carry_next = data_byte[3:0];
            flush_sym  = {data_byte[3:0], 1'b0};
            pos_next   = 3'd3;
            rem_last   = 3'd4;
            rem_mid    = 3'd0;
         end
         3'd3: begin
            sym0       = {carry_bits_ff[3:0], data_byte[7]};
            sym1       = data_byte[6:2];
            carry_next = {2'b00, data_byte[1:0]};
            flush_sym  = {data_byte[1:0], 3'b000};
            pos_next   = 3'd4;
            rem_last   = 3'd3;
            rem_mid    = 3'd1;
         end
         3'd4: begin
            sym0       = {carry_bits_ff[1:0], data_byte[7:5]};
            sym1       = data_byte[4:0];
            has_flush  = 1'b0;
            carry_next = 4'd0;
            flush_sym  = 5'd0;
            pos_next   = 3'd0;
            rem_last   = 3'd1;
            rem_mid    = 3'd1;
         end
         default: begin
            sym0       = data_byte[7:3];
            two_chars  = 1'b0;
            carry_next = {1'b0, data_byte[2:0]};
            flush_sym  = {data_byte[2:0], 2'b00};
            pos_next   = 3'd1;
            rem_last   = 3'd7;
            rem_mid    = 3'd0;
         end
      endcase
   end

   always_comb begin
      bundle.chars    = {GROUP_CHARS{PAD_CHAR}};
      bundle.chars[0] = b32h_char(sym0);
      if (two_chars) begin
         bundle.chars[1] = b32h_char(sym1);
         if (has_flush) begin
            bundle.chars[2] = b32h_char(flush_sym);
         end
      end else begin
         bundle.chars[1] = b32h_char(flush_sym);
      end
      bundle.rem  = last_byte ? rem_last : rem_mid;
      bundle.last = last_byte;
   end

   always_comb begin
      carry_bits_in     = carry_bits_ff;
      group_position_in = group_position_ff;
      if (accept) begin
         carry_bits_in     = last_byte ? 4'd0 : carry_next;
         group_position_in = last_byte ? 3'd0 : pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_bits_ff     <= 4'd0;
         group_position_ff <= 3'd0;
      end else begin
         carry_bits_ff     <= carry_bits_in;
         group_position_ff <= group_position_in;
      end
   end

   `B32H_ASSERT(a_pos_range, group_position_ff <= 3'd4)
   `B32H_ASSERT_MSG(a_last_clears, accept && last_byte |=> group_position_ff == 3'd0 && carry_bits_ff == 4'd0, "state not cleared after last byte")
   `B32H_ASSERT_MSG(a_group_wraps, accept && !last_byte && group_position_ff == 3'd4 |=> group_position_ff == 3'd0 && carry_bits_ff == 4'd0, "group did not wrap cleanly")

endmodule

// ===== rtl/core/b32h_serializer.sv =====
// Bundle holding register and one-character-per-cycle output register, held by rsp_stall.
`timescale 1ns / 1ps
`include "base32hex_stream_encoder_macros.svh"

module b32h_serializer import b32h_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  b32h_bundle_type bundle,
   output logic            slot_free,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_end_of_text
);

   b32h_bundle_type bundle_ff;
   b32h_bundle_type bundle_in;
   logic            bundle_valid_ff;
   logic            bundle_valid_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [7:0]      out_char_ff;
   logic [7:0]      out_char_in;
   logic            end_of_text_ff;
   logic            end_of_text_in;
   logic            out_load;
   logic            emit;
   logic            done;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign emit      = bundle_valid_ff && out_load;
   assign done      = emit && (bundle_ff.rem == 3'd0);
   assign slot_free = !bundle_valid_ff || done;

   always_comb begin
      bundle_in       = bundle_ff;
      bundle_valid_in = bundle_valid_ff;
      if (load) begin
         bundle_in       = bundle;
         bundle_valid_in = 1'b1;
      end else if (emit) begin
         bundle_in.chars = {PAD_CHAR, bundle_ff.chars[GROUP_CHARS-1:1]};
         bundle_in.rem   = bundle_ff.rem - 3'd1;
         bundle_valid_in = !done;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      out_char_in    = out_char_ff;
      end_of_text_in = end_of_text_ff;
      if (out_load) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         out_char_in    = bundle_ff.chars[0];
         end_of_text_in = bundle_ff.last && (bundle_ff.rem == 3'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bundle_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         bundle_valid_ff <= bundle_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff      <= bundle_in;
      out_char_ff    <= out_char_in;
      end_of_text_ff <= end_of_text_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = out_char_ff;
   assign rsp_end_of_text = end_of_text_ff;

   `B32H_ASSERT_MSG(a_no_overwrite, load |-> slot_free, "bundle overwritten before drained")
   `B32H_ASSERT_MSG(a_countdown, emit && bundle_ff.rem != 3'd0 |=> bundle_valid_ff && bundle_ff.rem == $past(bundle_ff.rem) - 3'd1, "character count skipped")
   `B32H_ASSERT(a_drain_empties, done && !load |=> !bundle_valid_ff)

endmodule
